// ===== sv/dmsd_pkg.sv =====
// Shared types and constants for the drive mixer and servo duty pipeline.
`default_nettype none

package dmsd_pkg;

  localparam int CMD_W   = 11;
  localparam int DUTY_W  = 12;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int NLANE   = 3;

  localparam int LANE_LEFT  = 0;
  localparam int LANE_RIGHT = 1;
  localparam int LANE_WINCH = 2;

  // Quotient bits resolved by each divider stage.
  localparam int BITS_PER_STG = 2;
  // Quotient bits of the mix rescale divider (result magnitude up to 1000).
  localparam int MIX_QW       = 10;
  // Numerator of the rescale: magnitude up to 2000 times 1000.
  localparam int MIX_NUM_W    = 21;

  // Map product (cmd + 1000) * |max - min| and its division by 2000 = 16 * 125.
  localparam int MAP_X_W   = CMD_W + CFG_W;
  localparam int DIV_SHIFT = 4;
  localparam int MAP_Y_W   = MAP_X_W - DIV_SHIFT;
  localparam int RECIP_W   = 24;
  localparam int RECIP_SH  = 30;
  localparam int MAP_P_W   = MAP_Y_W + RECIP_W;
  localparam int DUTY_N_W  = CFG_W + DUTY_W;

  // Fill-cycle latency from accepted request to result strobe.
  localparam int PIPE_LAT = 20;

  typedef logic signed [CMD_W-1:0] cmd_t;
  typedef logic [DUTY_W-1:0]       duty_t;
  typedef logic [CFG_W-1:0]        cfg_t;
  typedef logic [IDX_W-1:0]        cfg_idx_t;

  localparam cmd_t  CMD_FULL   = 11'sd1000;
  localparam logic [CMD_W-1:0] CMD_FULL_U = 11'd1000;
  localparam duty_t DUTY_MAX   = 12'd4095;
  localparam int    DIV_ODD    = 125;
  localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589934;

  typedef enum logic [IDX_W-1:0] {
    CFG_PULSE_MIN = 2'd0,
    CFG_PULSE_MAX = 2'd1,
    CFG_PERIOD    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic vld;
    logic direct;
  } dmsd_ctl_t;

  typedef struct packed {
    cfg_t pulse_min;
    cfg_t pulse_max;
    cfg_t period;
  } dmsd_cfg_t;

  localparam dmsd_cfg_t CFG_RESET = '{
    pulse_min: 16'd1000,
    pulse_max: 16'd2000,
    period:    16'd20000
  };

endpackage

`default_nettype wire

// ===== sv/drive_mix_to_servo_duty.sv =====
// Top level: config registers, arcade mixer and servo duty pipeline.
`default_nettype none

// Takes one request per clock: busy is low at every cycle outside reset, and
// each request accepted with start high yields exactly one result, shown on
// the out_ ports with out_strobe high for a single cycle. The receiver cannot
// stall the pipe, so results must be captured when strobed. The pipe holds
// two restoring dividers, each resolving two quotient bits per stage: five
// stages rescale the mixed wheel commands, six turn the pulse width into the
// 12-bit duty, with three multiply stages for the pulse map between them.
// Write the config registers only while no request is in flight; the pipe
// reads them live. Direct mode results carry winch_written low and a zero
// winch duty.

module drive_mix_to_servo_duty (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_opcode,
  input  dmsd_pkg::cmd_t       in_cmd_a,
  input  dmsd_pkg::cmd_t       in_cmd_b,
  input  dmsd_pkg::cmd_t       in_winch_cmd,
  output logic                 out_strobe,
  output dmsd_pkg::duty_t      out_left_duty,
  output dmsd_pkg::duty_t      out_right_duty,
  output dmsd_pkg::duty_t      out_winch_duty,
  output logic                 out_winch_written,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  dmsd_pkg::cfg_idx_t   cfg_index,
  input  dmsd_pkg::cfg_t       cfg_data
);
  import dmsd_pkg::*;

  dmsd_cfg_t cfg_r, cfg_nxt;
  dmsd_ctl_t in_ctl, mix_ctl, map_ctl;
  cmd_t      mix_cmd [NLANE];
  duty_t     map_duty [NLANE];

  // Nothing is taken while reset holds the pipe.
  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PULSE_MIN: cfg_nxt.pulse_min = cfg_data;
        CFG_PULSE_MAX: cfg_nxt.pulse_max = cfg_data;
        CFG_PERIOD:    cfg_nxt.period    = cfg_data;
        default:       cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_ctl.vld    = start && !busy;
  assign in_ctl.direct = in_opcode;

  dmsd_mix u_mix (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ctl       (in_ctl),
    .in_cmd_a     (in_cmd_a),
    .in_cmd_b     (in_cmd_b),
    .in_winch_cmd (in_winch_cmd),
    .out_ctl      (mix_ctl),
    .out_cmd      (mix_cmd)
  );

  dmsd_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_ctl   (mix_ctl),
    .in_cmd   (mix_cmd),
    .out_ctl  (map_ctl),
    .out_duty (map_duty)
  );

  assign out_strobe        = map_ctl.vld;
  assign out_left_duty     = map_duty[LANE_LEFT];
  assign out_right_duty    = map_duty[LANE_RIGHT];
  // Drop the winch in direct mode.
  assign out_winch_duty    = map_ctl.direct ? '0 : map_duty[LANE_WINCH];
  assign out_winch_written = !map_ctl.direct;

endmodule

`default_nettype wire

// ===== sv/dmsd_mix.sv =====
// Input saturation, arcade mixing and pipelined rescale of the wheel commands.
`default_nettype none

module dmsd_mix (
  input  logic                clk,
  input  logic                rst_n,
  input  dmsd_pkg::dmsd_ctl_t in_ctl,
  input  dmsd_pkg::cmd_t      in_cmd_a,
  input  dmsd_pkg::cmd_t      in_cmd_b,
  input  dmsd_pkg::cmd_t      in_winch_cmd,
  output dmsd_pkg::dmsd_ctl_t out_ctl,
  output dmsd_pkg::cmd_t      out_cmd [dmsd_pkg::NLANE]
);
  import dmsd_pkg::*;

  localparam int NSTG = MIX_QW / BITS_PER_STG;

  typedef logic signed [CMD_W:0] sum_t;
  typedef logic [MIX_NUM_W-1:0]  num_t;
  typedef logic [CMD_W-1:0]      mag_t;
  typedef logic [MIX_QW-1:0]     quo_t;

  typedef struct packed {
    num_t rem_l;
    num_t rem_r;
    quo_t q_l;
    quo_t q_r;
    mag_t m;
    logic neg_l;
    logic neg_r;
    logic scale;
    sum_t l;
    sum_t r;
    cmd_t w;
  } div_stg_t;

  localparam num_t NUM_FULL = num_t'(CMD_FULL_U);

  function automatic cmd_t sat_cmd(input cmd_t v);
    cmd_t res;
    res = v;
    if (v > CMD_FULL) res = CMD_FULL;
    else if (v < -CMD_FULL) res = -CMD_FULL;
    return res;
  endfunction

  // Stage 1: saturated commands
  dmsd_ctl_t s1_ctl_r;
  cmd_t      s1_a_r, s1_b_r, s1_w_r;
  // Stage 2: mixed wheel commands
  dmsd_ctl_t s2_ctl_r, s2_ctl_nxt;
  sum_t      s2_l_r, s2_r_r, s2_l_nxt, s2_r_nxt;
  cmd_t      s2_w_r;
  // Divider stages
  dmsd_ctl_t dv_ctl_r [NSTG+1];
  dmsd_ctl_t dv_ctl_nxt [NSTG+1];
  div_stg_t  dv_r [NSTG+1];
  div_stg_t  dv_nxt [NSTG+1];
  // Output stage
  dmsd_ctl_t out_ctl_r;
  cmd_t      out_cmd_r [NLANE];
  cmd_t      out_cmd_nxt [NLANE];

  always_comb begin
    sum_t a12, b12;
    a12 = sum_t'(s1_a_r);
    b12 = sum_t'(s1_b_r);
    s2_ctl_nxt = s1_ctl_r;
    if (s1_ctl_r.direct) begin
      s2_l_nxt = a12;
      s2_r_nxt = b12;
    end else begin
      s2_l_nxt = a12 + b12;
      s2_r_nxt = a12 - b12;
    end
  end

  always_comb begin
    sum_t abs_l, abs_r;
    mag_t mag_l, mag_r;
    num_t shd;
    int   sh;
    abs_l = s2_l_r[CMD_W] ? -s2_l_r : s2_l_r;
    abs_r = s2_r_r[CMD_W] ? -s2_r_r : s2_r_r;
    mag_l = abs_l[CMD_W-1:0];
    mag_r = abs_r[CMD_W-1:0];

    dv_ctl_nxt[0]   = s2_ctl_r;
    dv_nxt[0].neg_l = s2_l_r[CMD_W];
    dv_nxt[0].neg_r = s2_r_r[CMD_W];
    dv_nxt[0].m     = (mag_l > mag_r) ? mag_l : mag_r;
    dv_nxt[0].scale = !s2_ctl_r.direct && (dv_nxt[0].m > CMD_FULL_U);
    dv_nxt[0].rem_l = num_t'(mag_l) * NUM_FULL;
    dv_nxt[0].rem_r = num_t'(mag_r) * NUM_FULL;
    dv_nxt[0].q_l   = '0;
    dv_nxt[0].q_r   = '0;
    dv_nxt[0].l     = s2_l_r;
    dv_nxt[0].r     = s2_r_r;
    dv_nxt[0].w     = s2_w_r;

    // Restoring division, most significant quotient bits first.
    for (int j = 1; j <= NSTG; j++) begin
      dv_ctl_nxt[j] = dv_ctl_r[j-1];
      dv_nxt[j]     = dv_r[j-1];
      for (int k = 0; k < BITS_PER_STG; k++) begin
        sh  = MIX_QW - 1 - BITS_PER_STG * (j - 1) - k;
        shd = num_t'(dv_r[j-1].m) << sh;
        if (dv_nxt[j].rem_l >= shd) begin
          dv_nxt[j].rem_l = dv_nxt[j].rem_l - shd;
          dv_nxt[j].q_l   = {dv_nxt[j].q_l[MIX_QW-2:0], 1'b1};
        end else begin
          dv_nxt[j].q_l   = {dv_nxt[j].q_l[MIX_QW-2:0], 1'b0};
        end
        if (dv_nxt[j].rem_r >= shd) begin
          dv_nxt[j].rem_r = dv_nxt[j].rem_r - shd;
          dv_nxt[j].q_r   = {dv_nxt[j].q_r[MIX_QW-2:0], 1'b1};
        end else begin
          dv_nxt[j].q_r   = {dv_nxt[j].q_r[MIX_QW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    cmd_t ql, qr;
    ql = cmd_t'({1'b0, dv_r[NSTG].q_l});
    qr = cmd_t'({1'b0, dv_r[NSTG].q_r});
    if (dv_r[NSTG].scale) begin
      out_cmd_nxt[LANE_LEFT]  = dv_r[NSTG].neg_l ? -ql : ql;
      out_cmd_nxt[LANE_RIGHT] = dv_r[NSTG].neg_r ? -qr : qr;
    end else begin
      // Unscaled values already sit within full scale.
      out_cmd_nxt[LANE_LEFT]  = dv_r[NSTG].l[CMD_W-1:0];
      out_cmd_nxt[LANE_RIGHT] = dv_r[NSTG].r[CMD_W-1:0];
    end
    out_cmd_nxt[LANE_WINCH] = dv_r[NSTG].w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r  <= '0;
      s2_ctl_r  <= '0;
      dv_ctl_r  <= '{default: '0};
      out_ctl_r <= '0;
    end else begin
      s1_ctl_r  <= in_ctl;
      s2_ctl_r  <= s2_ctl_nxt;
      dv_ctl_r  <= dv_ctl_nxt;
      out_ctl_r <= dv_ctl_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    s1_a_r    <= sat_cmd(in_cmd_a);
    s1_b_r    <= sat_cmd(in_cmd_b);
    s1_w_r    <= sat_cmd(in_winch_cmd);
    s2_l_r    <= s2_l_nxt;
    s2_r_r    <= s2_r_nxt;
    s2_w_r    <= s1_w_r;
    dv_r      <= dv_nxt;
    out_cmd_r <= out_cmd_nxt;
  end

  assign out_ctl = out_ctl_r;
  assign out_cmd = out_cmd_r;

endmodule

`default_nettype wire

// ===== sv/dmsd_map.sv =====
// Command to pulse width map and pipelined pulse to 12-bit duty division, three lanes.
`default_nettype none

module dmsd_map (
  input  logic                clk,
  input  logic                rst_n,
  input  dmsd_pkg::dmsd_cfg_t cfg,
  input  dmsd_pkg::dmsd_ctl_t in_ctl,
  input  dmsd_pkg::cmd_t      in_cmd [dmsd_pkg::NLANE],
  output dmsd_pkg::dmsd_ctl_t out_ctl,
  output dmsd_pkg::duty_t     out_duty [dmsd_pkg::NLANE]
);
  import dmsd_pkg::*;

  localparam int DSTG = DUTY_W / BITS_PER_STG;

  typedef logic signed [CMD_W:0] sum_t;
  typedef logic signed [CFG_W:0] dif_t;
  typedef logic [MAP_X_W-1:0]    x_t;
  typedef logic [MAP_Y_W-1:0]    y_t;
  typedef logic [MAP_P_W-1:0]    p_t;
  typedef logic [DUTY_N_W-1:0]   n_t;

  typedef struct packed {
    logic  sat;
    n_t    rem;
    duty_t q;
  } dd_stg_t;

  localparam y_t Y_ODD = y_t'(DIV_ODD);

  // Span and period, which the user must keep held steady while requests are in flight; the block does not enforce this
  dif_t d;
  logic dn;
  cfg_t ad;
  cfg_t per_eff;

  dmsd_ctl_t m1_ctl_r, m2_ctl_r, m3_ctl_r, out_ctl_r;
  logic      m1_dn_r, m2_dn_r, m3_dn_r;
  x_t        m1_x_r [NLANE];
  x_t        m1_x_nxt [NLANE];
  p_t        m2_p_r [NLANE];
  p_t        m2_p_nxt [NLANE];
  y_t        m2_y_r [NLANE];
  cfg_t      m3_q_r [NLANE];
  cfg_t      m3_q_nxt [NLANE];
  dmsd_ctl_t dd_ctl_r [DSTG+1];
  dmsd_ctl_t dd_ctl_nxt [DSTG+1];
  dd_stg_t   dd_r [NLANE][DSTG+1];
  dd_stg_t   dd_nxt [NLANE][DSTG+1];
  duty_t     out_duty_r [NLANE];
  duty_t     out_duty_nxt [NLANE];

  always_comb begin
    dif_t ad_w;
    d       = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});
    dn      = d[CFG_W];
    ad_w    = dn ? -d : d;
    ad      = ad_w[CFG_W-1:0];
    // Zero period behaves as one.
    per_eff = (cfg.period == '0) ? cfg_t'(1) : cfg.period;
  end

  // Stage 1: (cmd + 1000) * |max - min|
  always_comb begin
    sum_t c12;
    for (int i = 0; i < NLANE; i++) begin
      c12 = sum_t'(in_cmd[i]) + sum_t'(CMD_FULL);
      m1_x_nxt[i] = x_t'(c12[CMD_W-1:0]) * x_t'(ad);
    end
  end

  // Stage 2: divide by 16 by shift, then reciprocal multiply for 125.
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      m2_p_nxt[i] = p_t'(m1_x_r[i][MAP_X_W-1:DIV_SHIFT]) * p_t'(RECIP_125);
    end
  end

  // Stage 3: estimate is low by at most one; correct it.
  always_comb begin
    cfg_t qe;
    y_t   r;
    for (int i = 0; i < NLANE; i++) begin
      qe = m2_p_r[i][RECIP_SH+CFG_W-1:RECIP_SH];
      r  = m2_y_r[i] - y_t'(qe) * Y_ODD;
      m3_q_nxt[i] = (r >= Y_ODD) ? qe + cfg_t'(1) : qe;
    end
  end

  // Stage 4: pulse, clamp test and duty numerator; then restoring division.
  always_comb begin
    cfg_t pulse;
    n_t   shd;
    int   sh;
    dd_ctl_nxt[0] = m3_ctl_r;
    for (int j = 1; j <= DSTG; j++) begin
      dd_ctl_nxt[j] = dd_ctl_r[j-1];
    end
    for (int i = 0; i < NLANE; i++) begin
      pulse = m3_dn_r ? cfg.pulse_min - m3_q_r[i] : cfg.pulse_min + m3_q_r[i];
      // A pulse of a full period or more saturates the duty.
      dd_nxt[i][0].sat = (pulse >= per_eff);
      dd_nxt[i][0].rem = n_t'(pulse) * n_t'(DUTY_MAX);
      dd_nxt[i][0].q   = '0;
      for (int j = 1; j <= DSTG; j++) begin
        dd_nxt[i][j] = dd_r[i][j-1];
        for (int k = 0; k < BITS_PER_STG; k++) begin
          sh  = DUTY_W - 1 - BITS_PER_STG * (j - 1) - k;
          shd = n_t'(per_eff) << sh;
          if (dd_nxt[i][j].rem >= shd) begin
            dd_nxt[i][j].rem = dd_nxt[i][j].rem - shd;
            dd_nxt[i][j].q   = {dd_nxt[i][j].q[DUTY_W-2:0], 1'b1};
          end else begin
            dd_nxt[i][j].q   = {dd_nxt[i][j].q[DUTY_W-2:0], 1'b0};
          end
        end
      end
      out_duty_nxt[i] = dd_r[i][DSTG].sat ? DUTY_MAX : dd_r[i][DSTG].q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_ctl_r  <= '0;
      m2_ctl_r  <= '0;
      m3_ctl_r  <= '0;
      dd_ctl_r  <= '{default: '0};
      out_ctl_r <= '0;
    end else begin
      m1_ctl_r  <= in_ctl;
      m2_ctl_r  <= m1_ctl_r;
      m3_ctl_r  <= m2_ctl_r;
      dd_ctl_r  <= dd_ctl_nxt;
      out_ctl_r <= dd_ctl_r[DSTG];
    end
  end

  always_ff @(posedge clk) begin
    m1_dn_r <= dn;
    m2_dn_r <= m1_dn_r;
    m3_dn_r <= m2_dn_r;
    for (int i = 0; i < NLANE; i++) begin
      m1_x_r[i] <= m1_x_nxt[i];
      m2_p_r[i] <= m2_p_nxt[i];
      m2_y_r[i] <= m1_x_r[i][MAP_X_W-1:DIV_SHIFT];
      m3_q_r[i] <= m3_q_nxt[i];
    end
    dd_r       <= dd_nxt;
    out_duty_r <= out_duty_nxt;
  end

  assign out_ctl  = out_ctl_r;
  assign out_duty = out_duty_r;

endmodule

`default_nettype wire

// ===== sv/dmsd_chk.sv =====
// Port-level checker for the drive mixer, bound to the top level.
`default_nettype none

module dmsd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               in_opcode,
  input logic               out_strobe,
  input dmsd_pkg::duty_t    out_winch_duty,
  input logic               out_winch_written
);
  import dmsd_pkg::*;

  // Every accepted request comes out after the fixed latency.
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##PIPE_LAT out_strobe)
    else $error("accepted request produced no result");

  // No result without a request accepted that long ago.
  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without matching request");

  // Winch flag follows the mode of the request it belongs to.
  a_winch_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_winch_written == !$past(in_opcode, PIPE_LAT)))
    else $error("winch flag does not match request mode");

  a_winch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_winch_written |-> (out_winch_duty == '0))
    else $error("unwritten winch carries a nonzero duty");

endmodule

bind drive_mix_to_servo_duty dmsd_chk u_chk (.*);

`default_nettype wire
